// ===== hdl/iou_pkg.sv =====
// Shared types and constants for the box intersection-over-union pipeline.
// Used by every module under hdl; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package iou_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int QUO_W         = FRACTION_BITS + 1;
  localparam int RATIO_W       = 17;
  localparam int COORD_W       = 16;
  localparam int SIZE_W        = 15;
  localparam int AREA_W        = 2 * SIZE_W;
  localparam int UNION_W       = AREA_W + 1;
  localparam int REM_W         = UNION_W + 1;
  localparam int IN_TDATA_W    = 128;
  localparam int OUT_TDATA_W   = 24;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_left;
    logic signed [COORD_W-1:0] first_top;
    logic [SIZE_W-1:0]         first_width;
    logic [SIZE_W-1:0]         first_height;
    logic signed [COORD_W-1:0] second_left;
    logic signed [COORD_W-1:0] second_top;
    logic [SIZE_W-1:0]         second_width;
    logic [SIZE_W-1:0]         second_height;
  } pair_t;

  // Overlap rectangle edges after the first stage.
  typedef struct packed {
    logic signed [COORD_W-1:0] xl;
    logic signed [COORD_W-1:0] yt;
    logic signed [COORD_W:0]   xr;
    logic signed [COORD_W:0]   yb;
    logic [SIZE_W-1:0]         w1;
    logic [SIZE_W-1:0]         h1;
    logic [SIZE_W-1:0]         w2;
    logic [SIZE_W-1:0]         h2;
  } edge_t;

  // Overlap size and box sizes handed to the area stages.
  typedef struct packed {
    logic [SIZE_W-1:0] ow;
    logic [SIZE_W-1:0] oh;
    logic [SIZE_W-1:0] w1;
    logic [SIZE_W-1:0] h1;
    logic [SIZE_W-1:0] w2;
    logic [SIZE_W-1:0] h2;
    logic              disjoint;
  } geom_t;

  // Dividend, divisor and status handed to the divider.
  typedef struct packed {
    logic [AREA_W-1:0]  inter;
    logic [UNION_W-1:0] uni;
    logic               kill;
    logic               empty;
  } quot_in_t;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic               empty;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/iou_geom.sv =====
// Overlap geometry: two register stages that clip the boxes to their overlap.
// Depends on iou_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iou_geom
  import iou_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire logic  in_valid,
  input  wire pair_t in_pair,
  output logic       out_valid,
  output geom_t      out_geom
);

  logic signed [COORD_W-1:0] l1, t1, l2, t2;
  logic signed [COORD_W:0]   r1, r2, b1, b2;
  edge_t                     edge_nxt, edge_r;
  logic                      v1_r, v2_r;
  logic signed [COORD_W+1:0] ow_full, oh_full;
  geom_t                     geom_nxt, geom_r;

  always_comb begin
    l1 = in_pair.first_left;
    t1 = in_pair.first_top;
    l2 = in_pair.second_left;
    t2 = in_pair.second_top;
    r1 = $signed({l1[COORD_W-1], l1}) + $signed({2'b00, in_pair.first_width});
    r2 = $signed({l2[COORD_W-1], l2}) + $signed({2'b00, in_pair.second_width});
    b1 = $signed({t1[COORD_W-1], t1}) + $signed({2'b00, in_pair.first_height});
    b2 = $signed({t2[COORD_W-1], t2}) + $signed({2'b00, in_pair.second_height});
    edge_nxt.xl = (l1 > l2) ? l1 : l2;
    edge_nxt.yt = (t1 > t2) ? t1 : t2;
    edge_nxt.xr = (r1 < r2) ? r1 : r2;
    edge_nxt.yb = (b1 < b2) ? b1 : b2;
    edge_nxt.w1 = in_pair.first_width;
    edge_nxt.h1 = in_pair.first_height;
    edge_nxt.w2 = in_pair.second_width;
    edge_nxt.h2 = in_pair.second_height;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      edge_r <= edge_nxt;
    end
  end

  // A negative overlap extent means the boxes are disjoint; the low bits are
  // then meaningless and the area stage ignores them.
  always_comb begin
    ow_full = $signed({edge_r.xr[COORD_W], edge_r.xr})
            - $signed({{2{edge_r.xl[COORD_W-1]}}, edge_r.xl});
    oh_full = $signed({edge_r.yb[COORD_W], edge_r.yb})
            - $signed({{2{edge_r.yt[COORD_W-1]}}, edge_r.yt});
    geom_nxt.ow       = ow_full[SIZE_W-1:0];
    geom_nxt.oh       = oh_full[SIZE_W-1:0];
    geom_nxt.w1       = edge_r.w1;
    geom_nxt.h1       = edge_r.h1;
    geom_nxt.w2       = edge_r.w2;
    geom_nxt.h2       = edge_r.h2;
    geom_nxt.disjoint = ow_full[COORD_W+1] | oh_full[COORD_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geom_r <= geom_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_geom  = geom_r;

endmodule

`default_nettype wire

// ===== hdl/iou_area.sv =====
// Area stages: three parallel 15x15 products, then the union area and status.
// Depends on iou_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iou_area
  import iou_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire logic  in_valid,
  input  wire geom_t in_geom,
  output logic       out_valid,
  output quot_in_t   out_quot
);

  logic [AREA_W-1:0]  inter_nxt, a1_nxt, a2_nxt;
  logic [AREA_W-1:0]  inter_r, a1_r, a2_r;
  logic               dis_r;
  logic               v3_r, v4_r;
  logic [UNION_W-1:0] uni;
  quot_in_t           quot_nxt, quot_r;

  assign inter_nxt = in_geom.disjoint ? '0
                   : ({{SIZE_W{1'b0}}, in_geom.ow} * {{SIZE_W{1'b0}}, in_geom.oh});
  assign a1_nxt    = {{SIZE_W{1'b0}}, in_geom.w1} * {{SIZE_W{1'b0}}, in_geom.h1};
  assign a2_nxt    = {{SIZE_W{1'b0}}, in_geom.w2} * {{SIZE_W{1'b0}}, in_geom.h2};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inter_r <= inter_nxt;
      a1_r    <= a1_nxt;
      a2_r    <= a2_nxt;
      dis_r   <= in_geom.disjoint;
    end
  end

  // The intersection never exceeds either box area, so the union is
  // non-negative and fits one bit above an area.
  always_comb begin
    uni            = {1'b0, a1_r} + {1'b0, a2_r} - {1'b0, inter_r};
    quot_nxt.inter = inter_r;
    quot_nxt.uni   = uni;
    quot_nxt.kill  = dis_r | (uni == '0);
    quot_nxt.empty = ~dis_r & (uni == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quot_r <= quot_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_quot  = quot_r;

endmodule

`default_nettype wire

// ===== hdl/iou_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on iou_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iou_div
  import iou_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     en,
  input  wire logic     in_valid,
  input  wire quot_in_t in_quot,
  output logic          out_valid,
  output result_t       out_result
);

  logic [REM_W-1:0]   rem_in   [QUO_W];
  logic [QUO_W-1:0]   q_in     [QUO_W];
  logic [UNION_W-1:0] uni_in   [QUO_W];
  logic               kill_in  [QUO_W];
  logic               empty_in [QUO_W];
  logic               v_in     [QUO_W];

  logic [REM_W:0]     diff     [QUO_W];
  logic [REM_W-1:0]   rem_nxt  [QUO_W];
  logic [QUO_W-1:0]   q_nxt    [QUO_W];

  logic [REM_W-1:0]   rem_r    [QUO_W];
  logic [QUO_W-1:0]   q_r      [QUO_W];
  logic [UNION_W-1:0] uni_r    [QUO_W];
  logic               kill_r   [QUO_W];
  logic               empty_r  [QUO_W];
  logic               v_r      [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    // The first stage tests the integer bit: the intersection is at most the
    // union, so the remainder stays below the divisor from then on.
    if (i == 0) begin : g_first
      assign rem_in[i]   = {{(REM_W-AREA_W){1'b0}}, in_quot.inter};
      assign q_in[i]     = '0;
      assign uni_in[i]   = in_quot.uni;
      assign kill_in[i]  = in_quot.kill;
      assign empty_in[i] = in_quot.empty;
      assign v_in[i]     = in_valid;
    end else begin : g_next
      assign rem_in[i]   = {rem_r[i-1][REM_W-2:0], 1'b0};
      assign q_in[i]     = q_r[i-1];
      assign uni_in[i]   = uni_r[i-1];
      assign kill_in[i]  = kill_r[i-1];
      assign empty_in[i] = empty_r[i-1];
      assign v_in[i]     = v_r[i-1];
    end

    assign diff[i]    = {1'b0, rem_in[i]} - {2'b00, uni_in[i]};
    assign rem_nxt[i] = diff[i][REM_W] ? rem_in[i] : diff[i][REM_W-1:0];
    assign q_nxt[i]   = {q_in[i][QUO_W-2:0], ~diff[i][REM_W]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]   <= rem_nxt[i];
        q_r[i]     <= q_nxt[i];
        uni_r[i]   <= uni_in[i];
        kill_r[i]  <= kill_in[i];
        empty_r[i] <= empty_in[i];
      end
    end
  end

  // Disjoint boxes and an empty union both report a zero ratio.
  assign out_valid        = v_r[QUO_W-1];
  assign out_result.ratio = kill_r[QUO_W-1] ? '0 : RATIO_W'(q_r[QUO_W-1]);
  assign out_result.empty = empty_r[QUO_W-1];

endmodule

`default_nettype wire

// ===== hdl/box_intersection_over_union.sv =====
// Pipeline: 2 geometry, 2 area and FRACTION_BITS + 1 divider stages, then the
// output register. Throughput: one box pair per cycle while the skid register
// is empty; the pipeline moves as one, and a skid register behind the output
// lets one more beat in while a result waits.
// Reset (rst_n low, synchronous) clears every valid bit; data registers keep
// whatever they hold.
// Top level: stream ports, pipeline chain and output/skid registers.
// Depends on iou_pkg, iou_geom, iou_area and iou_div.
`timescale 1ns / 1ps
`default_nettype none

module box_intersection_over_union
  import iou_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // first_left, first_top, first_width, first_height, second_left,
  // second_top, second_width, second_height, then zero padding
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // overlap_ratio, then zero padding
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // union_empty
  output logic                        out_tuser
);

  logic     en;
  pair_t    pair;
  logic     geom_valid, quot_valid, res_valid;
  geom_t    geom;
  quot_in_t quot;
  result_t  res;
  logic     out_v_r, skid_v_r;
  result_t  out_r, skid_r;

  assign en        = ~skid_v_r;
  assign in_tready = en;

  assign pair.first_left    = in_tdata[15:0];
  assign pair.first_top     = in_tdata[31:16];
  assign pair.first_width   = in_tdata[46:32];
  assign pair.first_height  = in_tdata[61:47];
  assign pair.second_left   = in_tdata[77:62];
  assign pair.second_top    = in_tdata[93:78];
  assign pair.second_width  = in_tdata[108:94];
  assign pair.second_height = in_tdata[123:109];

  iou_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_pair   (pair),
    .out_valid (geom_valid),
    .out_geom  (geom)
  );

  iou_area u_area (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (geom_valid),
    .in_geom   (geom),
    .out_valid (quot_valid),
    .out_quot  (quot)
  );

  iou_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (quot_valid),
    .in_quot    (quot),
    .out_valid  (res_valid),
    .out_result (res)
  );

  // When the output beat is held, a result leaving the pipeline parks in the
  // skid register, and the pipeline stops until the skid drains.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_tready || !out_v_r) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= res_valid;
      end
    end else if (res_valid && en) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_v_r) begin
      if (skid_v_r) begin
        out_r <= skid_r;
      end else begin
        out_r <= res;
      end
    end else if (res_valid && en) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_TDATA_W-RATIO_W){1'b0}}, out_r.ratio};
  assign out_tuser  = out_r.empty;

endmodule

`default_nettype wire
